>>> hdl/pbwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the wire-format tokenizer.
// Used by every module in hdl but pbwt_fifo; depends on nothing else.
package pbwt_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int VARINT_LAST_INDEX = 9;
    localparam logic [63:0] FIXED32_BYTES = 64'd4;
    localparam logic [63:0] FIXED64_BYTES = 64'd8;

    typedef enum logic [2:0] {
        WT_VARINT = 3'd0,
        WT_I64    = 3'd1,
        WT_LDELIM = 3'd2,
        WT_SGROUP = 3'd3,
        WT_EGROUP = 3'd4,
        WT_I32    = 3'd5,
        WT_RSVD6  = 3'd6,
        WT_RSVD7  = 3'd7
    } wire_t;

    typedef enum logic [2:0] {
        KIND_TAG     = 3'd0,
        KIND_VARINT  = 3'd1,
        KIND_FIXED32 = 3'd2,
        KIND_FIXED64 = 3'd3,
        KIND_LENGTH  = 3'd4,
        KIND_PAYLOAD = 3'd5,
        KIND_END     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO_FIELD = 2'd1,
        STAT_BAD_WIRE  = 2'd2,
        STAT_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // A byte after the front end has split it into varint parts.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [6:0] low7;
        logic       cont;
        logic       last_byte;
    } byte_info_t;

    typedef struct packed {
        kind_t      token_kind;
        logic [31:0] field_number;
        logic [2:0] wire_type;
        logic [63:0] value;
        logic       payload_end;
        logic       stream_end;
        status_t    status;
    } token_t;

endpackage

>>> hdl/protobuf_wire_tokenizer_top.sv
`timescale 1ns / 1ps
// Top level of the wire-format tokenizer: front end, back end and result queue.
// Depends on pbwt_pkg, pbwt_front, pbwt_back and pbwt_fifo.
//
// Usage: bytes of a serialized message enter on the input queue side; a
// transaction happens when push is high and full is low, carrying one byte and
// a mark on the last byte of the message. Tokens leave on the result queue
// side: the oldest token is on token while empty is low, and a transaction
// happens when pop is high and empty is low. Each byte yields zero or one token.
// The state machine reads a byte from the input queue and writes its token to
// the result queue in the same cycle, so a byte is held in the input queue
// registers and its token in the result queue registers before it is popped.
// Throughput: one byte per cycle while the result queue has room; the state
// machine's logic is bounded by its 64-bit shift-or and length decrement.
// When the receiver stops popping, the result queue fills, the state machine
// holds, and full rises after the input queue fills as well; nothing is lost.
// Reset clears both queues and returns the parser to expecting a tag; the
// last byte of every message does the same for the parser state.
module protobuf_wire_tokenizer_top
    import pbwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    input  logic     pop,
    output token_t   token,
    output logic     empty
);

    byte_info_t info;
    logic       info_empty;
    logic       take;
    logic       out_full;
    logic       tok_push;
    token_t     tok;

    pbwt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .take       (take),
        .info       (info),
        .info_empty (info_empty)
    );

    pbwt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .info       (info),
        .info_empty (info_empty),
        .take       (take),
        .out_full   (out_full),
        .tok_push   (tok_push),
        .tok        (tok)
    );

    pbwt_fifo #(
        .T     (token_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (tok_push),
        .wr_item (tok),
        .full    (out_full),
        .pop     (pop),
        .rd_item (token),
        .empty   (empty)
    );

endmodule

>>> hdl/pbwt_fifo.sv
`timescale 1ns / 1ps
// Small register-based queue with push/full and pop/empty sides.
// Depends on no package; the item type is a parameter.
module pbwt_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wr_item,
    output logic full,
    input  logic pop,
    output T     rd_item,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> hdl/pbwt_front.sv
`timescale 1ns / 1ps
// Front end: accepts message bytes, splits off the varint continuation bit
// and the seven value bits, and queues them for the back end. Uses pbwt_pkg.
module pbwt_front
    import pbwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  in_item_t   item,
    output logic       full,
    input  logic       take,
    output byte_info_t info,
    output logic       info_empty
);

    byte_info_t classified;

    always_comb
    begin
        classified.data_byte = item.data_byte;
        classified.low7      = item.data_byte[6:0];
        classified.cont      = item.data_byte[7];
        classified.last_byte = item.last_byte;
    end

    pbwt_fifo #(
        .T     (byte_info_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (classified),
        .full    (full),
        .pop     (take),
        .rd_item (info),
        .empty   (info_empty)
    );

endmodule

>>> hdl/pbwt_back.sv
`timescale 1ns / 1ps
// Back end: the wire-format state machine. Takes one classified byte per
// cycle when the result queue has room and emits at most one token. Uses pbwt_pkg.
module pbwt_back
    import pbwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_info_t info,
    input  logic       info_empty,
    output logic       take,
    input  logic       out_full,
    output logic       tok_push,
    output token_t     tok
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  shift_reg, shift_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wire_reg, wire_next;
    logic [63:0] left_reg, left_next;

    logic        fire;
    logic [3:0]  vn;
    logic [5:0]  vshift;
    logic [63:0] acc_var;
    logic        var_done;
    logic [2:0]  fidx;
    logic [63:0] acc_fix;
    logic [63:0] left_dec;
    logic        left_zero;
    logic [31:0] tag_field;
    logic [2:0]  tag_wire;
    logic        last;

    assign fire = !info_empty && !out_full;
    assign take = fire;
    assign last = info.last_byte;

    // Varint step: the byte index saturates at the tenth byte.
    assign vn       = (shift_reg > 4'(VARINT_LAST_INDEX)) ? 4'(VARINT_LAST_INDEX) : shift_reg;
    assign vshift   = 6'(vn) * 6'd7;
    assign acc_var  = acc_reg | (64'(info.low7) << vshift);
    assign var_done = !info.cont || (vn == 4'(VARINT_LAST_INDEX)) || last;

    assign fidx    = shift_reg[2:0];
    assign acc_fix = acc_reg | (64'(info.data_byte) << {fidx, 3'b000});

    assign left_dec  = (left_reg != '0) ? left_reg - 64'd1 : '0;
    assign left_zero = (left_dec == '0);

    assign tag_field = acc_var[34:3];
    assign tag_wire  = acc_var[2:0];

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        left_next  = left_reg;
        tok_push   = 1'b0;
        tok.token_kind   = KIND_END;
        tok.field_number = field_reg;
        tok.wire_type    = wire_reg;
        tok.value        = '0;
        tok.payload_end  = 1'b0;
        tok.stream_end   = last;
        tok.status       = STAT_OK;

        if (fire)
        begin
            unique case (phase_reg)
                PH_VARINT:
                begin
                    acc_next   = acc_var;
                    shift_next = vn + 4'd1;
                    if (var_done)
                    begin
                        tok_push       = 1'b1;
                        tok.token_kind = KIND_VARINT;
                        tok.value      = acc_var;
                        phase_next     = PH_TAG;
                        shift_next     = '0;
                        acc_next       = '0;
                    end
                end
                PH_FIXED:
                begin
                    acc_next   = acc_fix;
                    shift_next = {1'b0, fidx} + 4'd1;
                    left_next  = left_dec;
                    if (left_zero)
                    begin
                        tok_push       = 1'b1;
                        tok.token_kind = (wire_reg == WT_I32) ? KIND_FIXED32
                                                              : KIND_FIXED64;
                        tok.value      = acc_fix;
                        phase_next     = PH_TAG;
                        shift_next     = '0;
                        acc_next       = '0;
                    end
                    else if (last)
                    begin
                        tok_push       = 1'b1;
                        tok.token_kind = KIND_END;
                        tok.stream_end = 1'b1;
                        tok.status     = STAT_TRUNCATED;
                    end
                end
                PH_LENGTH:
                begin
                    acc_next   = acc_var;
                    shift_next = vn + 4'd1;
                    if (var_done)
                    begin
                        tok_push        = 1'b1;
                        tok.token_kind  = KIND_LENGTH;
                        tok.value       = acc_var;
                        tok.payload_end = (acc_var == '0);
                        tok.status      = (last && acc_var != '0) ? STAT_TRUNCATED
                                                                  : STAT_OK;
                        left_next       = acc_var;
                        phase_next      = (acc_var == '0) ? PH_TAG : PH_PAYLOAD;
                        shift_next      = '0;
                        acc_next        = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next       = left_dec;
                    tok_push        = 1'b1;
                    tok.token_kind  = KIND_PAYLOAD;
                    tok.value       = 64'(info.data_byte);
                    tok.payload_end = left_zero;
                    tok.status      = (last && !left_zero) ? STAT_TRUNCATED : STAT_OK;
                    if (left_zero)
                    begin
                        phase_next = PH_TAG;
                        shift_next = '0;
                        acc_next   = '0;
                    end
                end
                PH_DRAIN:
                begin
                end
                default:
                begin
                    acc_next   = acc_var;
                    shift_next = vn + 4'd1;
                    if (var_done)
                    begin
                        field_next       = tag_field;
                        wire_next        = tag_wire;
                        shift_next       = '0;
                        acc_next         = '0;
                        tok_push         = 1'b1;
                        tok.field_number = tag_field;
                        tok.wire_type    = tag_wire;
                        tok.value        = acc_var;
                        tok.token_kind   = KIND_TAG;
                        tok.status       = last ? STAT_TRUNCATED : STAT_OK;
                        if (tag_field == '0)
                        begin
                            tok.token_kind = KIND_END;
                            tok.stream_end = 1'b1;
                            tok.status     = STAT_ZERO_FIELD;
                            phase_next     = PH_DRAIN;
                        end
                        else
                        begin
                            unique case (wire_t'(tag_wire))
                                WT_VARINT:  phase_next = PH_VARINT;
                                WT_I64:
                                begin
                                    phase_next = PH_FIXED;
                                    left_next  = FIXED64_BYTES;
                                end
                                WT_I32:
                                begin
                                    phase_next = PH_FIXED;
                                    left_next  = FIXED32_BYTES;
                                end
                                WT_LDELIM:  phase_next = PH_LENGTH;
                                default:
                                begin
                                    tok.token_kind = KIND_END;
                                    tok.stream_end = 1'b1;
                                    tok.status     = STAT_BAD_WIRE;
                                    phase_next     = PH_DRAIN;
                                end
                            endcase
                        end
                    end
                end
            endcase

            // The end of the message returns everything to its reset state.
            if (last)
            begin
                phase_next = PH_TAG;
                shift_next = '0;
                acc_next   = '0;
                field_next = '0;
                wire_next  = '0;
                left_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            shift_reg <= '0;
            acc_reg   <= '0;
            field_reg <= '0;
            wire_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            acc_reg   <= acc_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            left_reg  <= left_next;
        end
    end

endmodule

>>> verif/protobuf_wire_tokenizer_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for protobuf_wire_tokenizer_top: message bytes in, tokens out.
// A scoreboard class tracks the parser state and predicts each token.
// Depends on pbwt_pkg and the tokenizer RTL only.
module protobuf_wire_tokenizer_top_test;
    import pbwt_pkg::*;

    localparam int DIRECTED_END_BYTES = 1250;
    localparam int TOTAL_BYTES = 1400;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Tracks the tokenizer state and holds the tokens still owed by the block.
    class token_scoreboard;
        token_t pending_tokens[$];
        phase_t phase;
        logic [3:0] shift_count;
        logic [63:0] acc;
        logic [31:0] cur_field;
        wire_t cur_wire;
        logic [63:0] bytes_left;
        int errors;
        int bytes_seen;
        int parsed_bytes;
        int tokens_seen;
        int kind_count[8];
        int status_count[4];

        function new();
            reset_state();
        endfunction

        function void reset_state();
            phase = PH_TAG;
            shift_count = '0;
            acc = '0;
            cur_field = '0;
            cur_wire = WT_VARINT;
            bytes_left = '0;
        endfunction

        function void clear_value();
            shift_count = '0;
            acc = '0;
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        // Returns 1 when the varint is complete.
        function bit add_varint_byte(logic [7:0] b, bit is_last);
            logic [3:0] n;
            n = (shift_count > 4'd9) ? 4'd9 : shift_count;
            acc |= {57'd0, b[6:0]} << (7 * n);
            shift_count = n + 4'd1;
            return !b[7] || n == 4'd9 || is_last;
        endfunction

        function void expect_token(kind_t k, logic [63:0] v, bit pend, bit send, status_t st);
            token_t t;
            t.token_kind = k;
            t.field_number = cur_field;
            t.wire_type = cur_wire;
            t.value = v;
            t.payload_end = pend;
            t.stream_end = send;
            t.status = st;
            pending_tokens.insert(pending_tokens.size(), t);
            kind_count[k]++;
            status_count[st]++;
        endfunction

        function void note_byte(in_item_t it);
            logic [7:0] b;
            bit is_last;
            logic [63:0] tagv;
            logic [2:0] idx;
            b = it.data_byte;
            is_last = it.last_byte;
            bytes_seen++;
            if (phase != PH_DRAIN)
                parsed_bytes++;
            case (phase)
                PH_VARINT:
                begin
                    if (add_varint_byte(b, is_last))
                    begin
                        expect_token(KIND_VARINT, acc, 1'b0, is_last, STAT_OK);
                        phase = PH_TAG;
                        clear_value();
                    end
                end
                PH_FIXED:
                begin
                    idx = shift_count[2:0];
                    acc |= {56'd0, b} << (8 * idx);
                    shift_count = {1'b0, idx} + 4'd1;
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 64'd1;
                    if (bytes_left == 0)
                    begin
                        expect_token((cur_wire == WT_I32) ? KIND_FIXED32 : KIND_FIXED64,
                                     acc, 1'b0, is_last, STAT_OK);
                        phase = PH_TAG;
                        clear_value();
                    end
                    else if (is_last)
                        expect_token(KIND_END, 64'd0, 1'b0, 1'b1, STAT_TRUNCATED);
                end
                PH_LENGTH:
                begin
                    if (add_varint_byte(b, is_last))
                    begin
                        tagv = acc;
                        expect_token(KIND_LENGTH, tagv, tagv == 0, is_last,
                                     (is_last && tagv != 0) ? STAT_TRUNCATED : STAT_OK);
                        bytes_left = tagv;
                        phase = (tagv == 0) ? PH_TAG : PH_PAYLOAD;
                        clear_value();
                    end
                end
                PH_PAYLOAD:
                begin
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 64'd1;
                    expect_token(KIND_PAYLOAD, {56'd0, b}, bytes_left == 0, is_last,
                                 (is_last && bytes_left != 0) ? STAT_TRUNCATED : STAT_OK);
                    if (bytes_left == 0)
                    begin
                        phase = PH_TAG;
                        clear_value();
                    end
                end
                PH_DRAIN:
                begin
                end
                default:
                begin
                    if (add_varint_byte(b, is_last))
                    begin
                        tagv = acc;
                        cur_field = tagv[34:3];
                        cur_wire = wire_t'(tagv[2:0]);
                        clear_value();
                        if (cur_field == 0)
                        begin
                            expect_token(KIND_END, tagv, 1'b0, 1'b1, STAT_ZERO_FIELD);
                            phase = PH_DRAIN;
                        end
                        else
                        begin
                            case (cur_wire)
                                WT_VARINT, WT_I64, WT_I32, WT_LDELIM:
                                begin
                                    // A good tag on the final byte has lost its body.
                                    expect_token(KIND_TAG, tagv, 1'b0, is_last,
                                                 is_last ? STAT_TRUNCATED : STAT_OK);
                                    if (cur_wire == WT_VARINT)
                                        phase = PH_VARINT;
                                    else if (cur_wire == WT_LDELIM)
                                        phase = PH_LENGTH;
                                    else
                                    begin
                                        bytes_left = (cur_wire == WT_I64) ?
                                                     FIXED64_BYTES : FIXED32_BYTES;
                                        phase = PH_FIXED;
                                    end
                                end
                                default:
                                begin
                                    expect_token(KIND_END, tagv, 1'b0, 1'b1, STAT_BAD_WIRE);
                                    phase = PH_DRAIN;
                                end
                            endcase
                        end
                    end
                end
            endcase
            if (is_last)
                reset_state();
        endfunction

        function int field_mismatch(string name, logic [63:0] e, logic [63:0] g);
            if (g !== e)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, e, g);
                return 1;
            end
            return 0;
        endfunction

        function void check_token(token_t got);
            token_t e;
            tokens_seen++;
            if (pending_tokens.size() == 0)
            begin
                $error("token with none expected: kind %0d value 0x%0h",
                       got.token_kind, got.value);
                errors++;
                return;
            end
            e = pending_tokens.pop_front();
            errors += field_mismatch("token_kind", 64'(e.token_kind), 64'(got.token_kind));
            errors += field_mismatch("field_number", 64'(e.field_number), 64'(got.field_number));
            errors += field_mismatch("wire_type", 64'(e.wire_type), 64'(got.wire_type));
            errors += field_mismatch("value", e.value, got.value);
            errors += field_mismatch("payload_end", 64'(e.payload_end), 64'(got.payload_end));
            errors += field_mismatch("stream_end", 64'(e.stream_end), 64'(got.stream_end));
            errors += field_mismatch("status", 64'(e.status), 64'(got.status));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    in_item_t item;
    logic full;
    logic pop;
    token_t token;
    logic empty;

    token_scoreboard sb;
    logic [7:0] msg_bytes[$];
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int full_stalls;
    int quiet_cycles;

    protobuf_wire_tokenizer_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .pop(pop),
        .token(token),
        .empty(empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transactions on both sides are sampled here, from values settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_byte(item);
            if (pop && !empty)
                sb.check_token(token);
            if (push && full)
                full_stalls++;
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("protobuf_wire_tokenizer_top verification failed");
                $finish;
            end
        end
    end

    // Token receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        bit held;
        held = 1'b0;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic void add_msg_byte(logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void put_varint(logic [63:0] v);
        do
        begin
            add_msg_byte({(v >> 7) != 0, v[6:0]});
            v = v >> 7;
        end
        while (v != 0);
    endfunction

    // One field, mostly well formed, with a few zero field numbers and bad wire types.
    function automatic void put_field();
        int pick;
        int len;
        logic [31:0] fnum;
        logic [63:0] tagv;
        wire_t w;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: fnum = $urandom;
            1: fnum = $urandom_range(16, 2047);
            default: fnum = $urandom_range(1, 15);
        endcase
        if (pick < 25)
            w = WT_VARINT;
        else if (pick < 40)
            w = WT_I64;
        else if (pick < 55)
            w = WT_I32;
        else if (pick < 88)
            w = WT_LDELIM;
        else
        begin
            case ($urandom_range(0, 3))
                0: w = WT_SGROUP;
                1: w = WT_EGROUP;
                2: w = WT_RSVD6;
                default: w = WT_RSVD7;
            endcase
        end
        if (pick >= 96)
            fnum = '0;
        tagv = {29'd0, fnum, w};
        // Tag bits above the 32-bit field number are dropped by the parser.
        if ($urandom_range(0, 15) == 0)
            tagv[63:35] = 29'($urandom);
        put_varint(tagv);
        case (w)
            WT_VARINT: put_varint(rand_wide());
            WT_I64: repeat (8) add_msg_byte(8'($urandom));
            WT_I32: repeat (4) add_msg_byte(8'($urandom));
            WT_LDELIM:
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 6);
                if ($urandom_range(0, 30) == 0)
                    put_varint(rand_wide());
                else
                    put_varint(64'(len));
                repeat (len) add_msg_byte(8'($urandom));
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void build_message();
        int r;
        int keep;
        msg_bytes.delete();
        repeat ($urandom_range(1, 5)) put_field();
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            keep = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > keep)
                void'(msg_bytes.pop_back());
        end
        else if (r < 22)
            repeat ($urandom_range(1, 12)) add_msg_byte(8'($urandom));
    endfunction

    task automatic send_byte(logic [7:0] b, bit is_last);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{data_byte: b, last_byte: is_last};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_message();
        foreach (msg_bytes[i])
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic wait_for_tokens();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        sb = new();
        full_stalls = 0;
        quiet_cycles = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero field number with bytes drained after it.
        msg_bytes = '{8'h07, 8'hFF, 8'h00};
        send_message();
        // Unsupported wire type (start group).
        msg_bytes = '{8'h0B, 8'h80};
        send_message();
        // Valid tag that ends the message.
        msg_bytes = '{8'h0A};
        send_message();
        // Fixed32 cut short by the end.
        msg_bytes = '{8'h0D, 8'h01, 8'h02};
        send_message();
        // Nonzero length on the final byte, then zero length on the final byte.
        msg_bytes = '{8'h12, 8'h03};
        send_message();
        msg_bytes = '{8'h12, 8'h00};
        send_message();
        // Payload cut short by the end.
        msg_bytes = '{8'h12, 8'h05, 8'hAA};
        send_message();
        // Largest field number, then a ten-byte varint of all ones.
        msg_bytes.delete();
        put_varint({29'd0, 32'hFFFF_FFFF, WT_LDELIM});
        add_msg_byte(8'h01);
        add_msg_byte(8'hFF);
        put_varint({29'd0, 32'd1, WT_VARINT});
        put_varint('1);
        send_message();

        while (sb.bytes_seen < DIRECTED_END_BYTES)
        begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if (!hold_done && sb.parsed_bytes >= 400)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sb.parsed_bytes >= 800)
            begin
                wait_for_tokens();
                pause_done = 1'b1;
            end
            build_message();
            send_message();
        end

        // Closing stretch at full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (sb.bytes_seen < TOTAL_BYTES)
        begin
            build_message();
            send_message();
        end
        wait_for_tokens();
        repeat (8) @(posedge clk);

        $display("Run covered %0d bytes (%0d parsed) and %0d tokens; %0s %0d cycles.",
                 sb.bytes_seen, sb.parsed_bytes, sb.tokens_seen,
                 "input held by full", full_stalls);
        $display("Tokens: tag %0d varint %0d fixed32 %0d fixed64 %0d length %0d",
                 sb.kind_count[KIND_TAG], sb.kind_count[KIND_VARINT],
                 sb.kind_count[KIND_FIXED32], sb.kind_count[KIND_FIXED64],
                 sb.kind_count[KIND_LENGTH]);
        $display("payload %0d end %0d; truncated %0d zero-field %0d bad-wire %0d.",
                 sb.kind_count[KIND_PAYLOAD], sb.kind_count[KIND_END],
                 sb.status_count[STAT_TRUNCATED], sb.status_count[STAT_ZERO_FIELD],
                 sb.status_count[STAT_BAD_WIRE]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("protobuf_wire_tokenizer_top verification clean");
        else
            $display("protobuf_wire_tokenizer_top verification failed");
        $finish;
    end

endmodule
